FILE: design/hiorf_pkg.sv
package hiorf_pkg;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [1:0] PWR_NONE = 2'd0;
  localparam logic [1:0] PWR_HALT = 2'd1;
  localparam logic [1:0] PWR_STOP = 2'd2;

  localparam logic [11:0] DMA_BASE = 12'h0B0;
  localparam logic [11:0] DMA_LAST = 12'h0DF;

  typedef struct packed {
    logic        cmd;
    logic [11:0] addr_offset;
    logic [7:0]  wdata;
    logic [9:0]  keys_pressed;
    logic [15:0] timer_count;
    logic [15:0] irq_raise;
  } in_item_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic [3:0] dma_start;
    logic [3:0] timer_start;
    logic [1:0] power_request;
  } out_item_t;

  // Keypad low byte: cancel opposing directions, then invert.
  function automatic logic [7:0] keypad_low(input logic [9:0] keys);
    logic [7:0] r;
    r = keys[7:0];
    if (r[7:6] == 2'b11) r[7:6] = 2'b00;
    if (r[5:4] == 2'b11) r[5:4] = 2'b00;
    return ~r;
  endfunction

endpackage

FILE: design/handheld_io_register_file.sv
// Byte-wide I/O register bank. One bus access is taken in every cycle (busy
// stays low); its result is strobed on out_valid once it has passed the input
// register and the result register, which sit around a single decode stage.
// The receiver cannot stall, so every result must be taken as it appears.
module handheld_io_register_file #(
  parameter int DMA_CHANNELS = 4,
  parameter int TIMER_COUNT  = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  hiorf_pkg::in_item_t  in_item,
  output logic                 out_valid,
  output hiorf_pkg::out_item_t out_item
);
  import hiorf_pkg::*;

  localparam int CW = $clog2(DMA_CHANNELS);
  localparam int TW = $clog2(TIMER_COUNT);

  logic [31:0] dma_source_r [DMA_CHANNELS];
  logic [31:0] dma_target_r [DMA_CHANNELS];
  logic [15:0] dma_length_r [DMA_CHANNELS];
  logic [11:0] dma_control_r [DMA_CHANNELS];
  logic [DMA_CHANNELS-1:0] dma_pending_r;
  logic [31:0] dma_run_source_r [DMA_CHANNELS];
  logic [31:0] dma_run_target_r [DMA_CHANNELS];
  logic [15:0] dma_run_length_r [DMA_CHANNELS];
  logic [15:0] timer_reload_r [TIMER_COUNT];
  logic [4:0]  timer_control_r [TIMER_COUNT];
  logic [TIMER_COUNT-1:0] timer_pending_r;
  logic [15:0] serial_words_r [4];
  logic [6:0]  serial_control_r;
  logic [7:0]  serial_byte_r;
  logic [11:0] keypad_control_r;
  logic [10:0] link_settings_r;
  logic [3:0]  link_control_r;
  logic [31:0] link_receive_r, link_transmit_r;
  logic [3:0]  link_status_r;
  logic [15:0] irq_enable_r, irq_flag_r;
  logic        irq_master_r, boot_done_r;
  logic [14:0] wait_control_r;
  logic [12:0] memory_control_r;

  in_item_t  in_r;
  logic      in_valid_r;
  out_item_t res_r;
  logic      res_valid_r;

  logic       dma_hit;
  logic [1:0] dma_ch2;
  logic [3:0] dma_sub;
  logic [CW-1:0] ch;
  logic [TW-1:0] tm;
  logic [11:0] off;
  logic [7:0]  d, dm;
  logic        wr;

  assign busy      = 1'b0;
  assign out_valid = res_valid_r;
  assign out_item  = res_r;

  hiorf_decode u_dec (
    .addr_offset(in_r.addr_offset), .dma_hit(dma_hit), .dma_ch(dma_ch2), .dma_sub(dma_sub)
  );

  assign off = in_r.addr_offset;
  assign d   = in_r.wdata;
  assign wr  = in_valid_r && (in_r.cmd == CMD_WRITE);
  assign ch  = CW'(dma_ch2);
  assign tm  = TW'(off[3:2]);
  // Gamepad request survives only on the last channel.
  assign dm  = (32'(ch) == DMA_CHANNELS - 1) ? d : (d & 8'hF7);

  logic tim_hit, ser_hit, lrx_hit, ltx_hit;
  assign tim_hit = off >= 12'h100 && off <= 12'h10F;
  assign ser_hit = off >= 12'h120 && off <= 12'h127;
  assign lrx_hit = off >= 12'h150 && off <= 12'h153;
  assign ltx_hit = off >= 12'h154 && off <= 12'h157;

  out_item_t res_nxt;
  logic [31:0] w32;
  logic [15:0] w16;
  logic [4:0]  tc;

  always_comb begin
    res_nxt = '0;
    w32 = 32'h0; w16 = 16'h0; tc = timer_control_r[tm];
    if (in_r.cmd == CMD_READ) begin
      if (dma_hit) begin
        if (dma_sub == 4'd10) res_nxt.rdata = {dma_control_r[ch][3:1], 1'b0, 4'h0} >> 0;
        else if (dma_sub == 4'd11) res_nxt.rdata = dma_control_r[ch][11:4];
        if (dma_sub == 4'd10) res_nxt.rdata = {dma_control_r[ch][3:1], 5'h0};
      end else if (tim_hit) begin
        case (off[1:0])
          2'd0: res_nxt.rdata = in_r.timer_count[7:0];
          2'd1: res_nxt.rdata = in_r.timer_count[15:8];
          2'd2: res_nxt.rdata = {tc[4:3], 3'b000, tc[2:0]};
          default: res_nxt.rdata = 8'h00;
        endcase
      end else if (ser_hit) begin
        w16 = serial_words_r[off[2:1]];
        res_nxt.rdata = off[0] ? w16[15:8] : w16[7:0];
      end else if (lrx_hit || ltx_hit) begin
        w32 = lrx_hit ? link_receive_r : link_transmit_r;
        res_nxt.rdata = 8'(w32 >> {off[1:0], 3'b000});
      end else begin
        case (off)
          12'h128: res_nxt.rdata = {serial_control_r[4], 3'b000, serial_control_r[3:0]};
          12'h129: res_nxt.rdata = {1'b0, serial_control_r[6], 1'b0, serial_control_r[5], 4'h0};
          12'h12A: res_nxt.rdata = serial_byte_r;
          12'h130: res_nxt.rdata = keypad_low(in_r.keys_pressed);
          12'h131: res_nxt.rdata = {6'h0, ~in_r.keys_pressed[9:8]};
          12'h132: res_nxt.rdata = keypad_control_r[7:0];
          12'h133: res_nxt.rdata = {keypad_control_r[11:10], 4'h0, keypad_control_r[9:8]};
          12'h134: res_nxt.rdata = link_settings_r[7:0];
          12'h135: res_nxt.rdata = {link_settings_r[10:9], 5'h0, link_settings_r[8]};
          12'h140: res_nxt.rdata = {1'b0, link_control_r[3], 3'b000, link_control_r[2:0]};
          12'h158: res_nxt.rdata = {2'b00, link_status_r[3:2], link_status_r[1], 1'b0,
                                    link_status_r[0], 1'b0};
          12'h200: res_nxt.rdata = irq_enable_r[7:0];
          12'h201: res_nxt.rdata = irq_enable_r[15:8];
          12'h202: res_nxt.rdata = irq_flag_r[7:0];
          12'h203: res_nxt.rdata = irq_flag_r[15:8];
          12'h204: res_nxt.rdata = wait_control_r[7:0];
          12'h205: res_nxt.rdata = {wait_control_r[14:13], 2'b00, wait_control_r[11:8]};
          12'h208: res_nxt.rdata = {7'h0, irq_master_r};
          12'h300: res_nxt.rdata = {7'h0, boot_done_r};
          12'h800: res_nxt.rdata = {2'b00, memory_control_r[4], 1'b0, memory_control_r[3:0]};
          12'h803: res_nxt.rdata = memory_control_r[12:5];
          default: res_nxt.rdata = 8'h00;
        endcase
      end
    end else begin
      if (dma_hit && dma_sub == 4'd11 && !dma_control_r[ch][11] && d[7])
        res_nxt.dma_start = 4'(1 << ch);
      if (tim_hit && off[1:0] == 2'd2 && !tc[4] && d[7])
        res_nxt.timer_start = 4'(1 << tm);
      if (off == 12'h301) res_nxt.power_request = d[7] ? PWR_STOP : PWR_HALT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
      for (int i = 0; i < DMA_CHANNELS; i++) begin
        dma_source_r[i] <= '0; dma_target_r[i] <= '0; dma_length_r[i] <= '0;
        dma_control_r[i] <= '0; dma_run_source_r[i] <= '0;
        dma_run_target_r[i] <= '0; dma_run_length_r[i] <= '0;
      end
      for (int i = 0; i < TIMER_COUNT; i++) begin
        timer_reload_r[i] <= '0; timer_control_r[i] <= '0;
      end
      for (int i = 0; i < 4; i++) serial_words_r[i] <= '0;
      dma_pending_r <= '0; timer_pending_r <= '0;
      serial_control_r <= '0; serial_byte_r <= '0; keypad_control_r <= '0;
      link_settings_r <= '0; link_control_r <= '0; link_receive_r <= '0;
      link_transmit_r <= '0; link_status_r <= '0; irq_enable_r <= '0;
      irq_flag_r <= '0; irq_master_r <= 1'b0; wait_control_r <= '0;
      boot_done_r <= 1'b0; memory_control_r <= '0;
    end else begin
      in_valid_r  <= start;
      res_valid_r <= in_valid_r;
      if (wr) begin
        if (dma_hit) begin
          case (dma_sub)
            4'd0, 4'd1, 4'd2, 4'd3:
              dma_source_r[ch][dma_sub[1:0]*8 +: 8] <= d;
            4'd4, 4'd5, 4'd6, 4'd7:
              dma_target_r[ch][dma_sub[1:0]*8 +: 8] <= d;
            4'd8: dma_length_r[ch][7:0] <= d;
            4'd9: dma_length_r[ch][15:8] <= d;
            4'd10: dma_control_r[ch][3:0] <= {d[7:5], 1'b0};
            4'd11: begin
              dma_control_r[ch][11:4] <= dm;
              if (!dma_control_r[ch][11] && d[7]) begin
                if (d[5:4] == 2'b00) dma_pending_r[ch] <= 1'b1;
                dma_run_source_r[ch] <= dma_source_r[ch];
                dma_run_target_r[ch] <= dma_target_r[ch];
                dma_run_length_r[ch] <= dma_length_r[ch];
              end else if (!d[7]) dma_pending_r[ch] <= 1'b0;
            end
            default: ;
          endcase
        end else if (tim_hit) begin
          case (off[1:0])
            2'd0: timer_reload_r[tm][7:0] <= d;
            2'd1: timer_reload_r[tm][15:8] <= d;
            2'd2: begin
              timer_control_r[tm] <= {d[7:6], d[2:0]};
              if (!timer_control_r[tm][4] && d[7]) timer_pending_r[tm] <= 1'b1;
            end
            default: ;
          endcase
        end else if (ser_hit) begin
          if (off[0]) serial_words_r[off[2:1]][15:8] <= d;
          else serial_words_r[off[2:1]][7:0] <= d;
        end else if (lrx_hit) begin
          link_receive_r[off[1:0]*8 +: 8] <= d;
        end else if (ltx_hit) begin
          link_transmit_r[off[1:0]*8 +: 8] <= d;
        end else begin
          case (off)
            12'h128: serial_control_r[4:0] <= {d[7], d[3:0]};
            12'h129: serial_control_r[6:5] <= {d[6], d[4]};
            12'h12A: serial_byte_r <= d;
            12'h132: keypad_control_r[7:0] <= d;
            12'h133: keypad_control_r[11:8] <= {d[7:6], d[1:0]};
            12'h134: link_settings_r[7:0] <= d;
            12'h135: link_settings_r[10:8] <= {d[7:6], d[0]};
            12'h140: link_control_r <= {d[6], d[2:0]};
            12'h158: link_status_r <= {d[5:4], d[3], d[1]};
            12'h200: irq_enable_r[7:0] <= d;
            12'h201: irq_enable_r[15:8] <= d;
            12'h204: wait_control_r[7:0] <= d;
            12'h205: wait_control_r[14:8] <= {d[7:6], 1'b0, d[3:0]};
            12'h208: irq_master_r <= d[0];
            12'h300: if (d[0]) boot_done_r <= 1'b1;
            12'h800: memory_control_r[4:0] <= {d[5], d[3:0]};
            12'h803: memory_control_r[12:5] <= d;
            default: ;
          endcase
        end
      end
      // Clear by writing ones first, then raise.
      if (in_valid_r) begin
        if (wr && off == 12'h202)
          irq_flag_r <= (irq_flag_r & ~{8'h00, d}) | in_r.irq_raise;
        else if (wr && off == 12'h203)
          irq_flag_r <= (irq_flag_r & ~{d, 8'h00}) | in_r.irq_raise;
        else
          irq_flag_r <= irq_flag_r | in_r.irq_raise;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) in_r <= in_item;
    res_r <= res_nxt;
  end
endmodule

FILE: design/hiorf_decode.sv
module hiorf_decode (
  input  logic [11:0] addr_offset,
  output logic        dma_hit,
  output logic [1:0]  dma_ch,
  output logic [3:0]  dma_sub
);
  import hiorf_pkg::*;

  logic [5:0] rel;

  // Split the DMA window into 12-byte channel blocks.
  always_comb begin
    rel     = 6'(addr_offset - DMA_BASE);
    dma_hit = (addr_offset >= DMA_BASE) && (addr_offset <= DMA_LAST);
    if (rel >= 6'd36) begin
      dma_ch = 2'd3; dma_sub = 4'(rel - 6'd36);
    end else if (rel >= 6'd24) begin
      dma_ch = 2'd2; dma_sub = 4'(rel - 6'd24);
    end else if (rel >= 6'd12) begin
      dma_ch = 2'd1; dma_sub = 4'(rel - 6'd12);
    end else begin
      dma_ch = 2'd0; dma_sub = rel[3:0];
    end
  end
endmodule

FILE: design/hiorf_checker.sv
module hiorf_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_valid,
  input hiorf_pkg::out_item_t out_item
);
  import hiorf_pkg::*;

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##2 out_valid) else $error("result beat missing");
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 2)) else $error("spurious result beat");
  a_power: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.power_request != 2'd3) else $error("bad power code");
  a_read_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.rdata != 8'h00) |->
      (out_item.dma_start == 4'h0 && out_item.timer_start == 4'h0))
    else $error("pulse on read");
endmodule

bind handheld_io_register_file hiorf_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_item(out_item)
);

FILE: test/handheld_io_register_file_tb.sv
module handheld_io_register_file_tb;
  import hiorf_pkg::*;

  class bus_scoreboard;
    logic [31:0] dsrc[4], dtgt[4], run_src[4], run_tgt[4];
    logic [15:0] dlen[4], run_len[4], dctl[4];
    logic        dpend[4], tpend[4];
    logic [15:0] treload[4], swords[4];
    logic [4:0]  tctl[4];
    logic [6:0]  sctl;
    logic [7:0]  sbyte;
    logic [11:0] kctl;
    logic [10:0] lset;
    logic [3:0]  lctl, lstat;
    logic [31:0] lrx, ltx;
    logic [15:0] ie, iflag;
    logic        ime, boot;
    logic [14:0] waitc;
    logic [12:0] memc;
    out_item_t   pending_q[$];
    int          errors;
    int          checked;
    int          dma_pulses, timer_pulses, power_hits;

    function new();
      for (int i = 0; i < 4; i++) begin
        dsrc[i] = 0; dtgt[i] = 0; run_src[i] = 0; run_tgt[i] = 0;
        dlen[i] = 0; run_len[i] = 0; dctl[i] = 0; dpend[i] = 0;
        tpend[i] = 0; treload[i] = 0; swords[i] = 0; tctl[i] = 0;
      end
      sctl = 0; sbyte = 0; kctl = 0; lset = 0; lctl = 0; lstat = 0;
      lrx = 0; ltx = 0; ie = 0; iflag = 0; ime = 0; boot = 0;
      waitc = 0; memc = 0; errors = 0; checked = 0;
      dma_pulses = 0; timer_pulses = 0; power_hits = 0;
    endfunction

    function logic [7:0] read_byte(in_item_t it);
      logic [11:0] a;
      logic [7:0]  r, k;
      int          rel, ch, sub;
      a = it.addr_offset;
      r = 8'h00;
      if (a >= DMA_BASE && a <= DMA_LAST) begin
        rel = a - DMA_BASE; ch = (rel / 12) % 4; sub = rel % 12;
        if (sub == 10) r = {dctl[ch][3:1], 5'h0};
        else if (sub == 11) r = dctl[ch][11:4];
      end else if (a >= 12'h100 && a <= 12'h10F) begin
        case (a[1:0])
          2'd0: r = it.timer_count[7:0];
          2'd1: r = it.timer_count[15:8];
          2'd2: r = {tctl[a[3:2]][4:3], 3'b000, tctl[a[3:2]][2:0]};
          default: r = 0;
        endcase
      end else if (a >= 12'h120 && a <= 12'h127) begin
        r = a[0] ? swords[a[2:1]][15:8] : swords[a[2:1]][7:0];
      end else if (a >= 12'h150 && a <= 12'h153) begin
        r = lrx >> (8 * a[1:0]);
      end else if (a >= 12'h154 && a <= 12'h157) begin
        r = ltx >> (8 * a[1:0]);
      end else begin
        case (a)
          12'h128: r = {sctl[4], 3'b000, sctl[3:0]};
          12'h129: r = {1'b0, sctl[6], 1'b0, sctl[5], 4'h0};
          12'h12A: r = sbyte;
          12'h130: begin
            k = it.keys_pressed[7:0];
            if (k[7:6] == 2'b11) k[7:6] = 2'b00;
            if (k[5:4] == 2'b11) k[5:4] = 2'b00;
            r = ~k;
          end
          12'h131: r = {6'b0, ~it.keys_pressed[9:8]};
          12'h132: r = kctl[7:0];
          12'h133: r = {kctl[11:10], 4'h0, kctl[9:8]};
          12'h134: r = lset[7:0];
          12'h135: r = {lset[10:9], 5'b0, lset[8]};
          12'h140: r = {1'b0, lctl[3], 3'b000, lctl[2:0]};
          12'h158: r = {2'b00, lstat[3:2], lstat[1], 1'b0, lstat[0], 1'b0};
          12'h200: r = ie[7:0];
          12'h201: r = ie[15:8];
          12'h202: r = iflag[7:0];
          12'h203: r = iflag[15:8];
          12'h204: r = waitc[7:0];
          12'h205: r = {waitc[14:13], 2'b00, waitc[11:8]};
          12'h208: r = {7'b0, ime};
          12'h300: r = {7'b0, boot};
          12'h800: r = {2'b00, memc[4], 1'b0, memc[3:0]};
          12'h803: r = memc[12:5];
          default: r = 0;
        endcase
      end
      return r;
    endfunction

    function void write_byte(in_item_t it, ref out_item_t o);
      logic [11:0] a;
      logic [7:0]  d;
      int          rel, ch, sub, t;
      logic        was;
      a = it.addr_offset;
      d = it.wdata;
      if (a >= DMA_BASE && a <= DMA_LAST) begin
        rel = a - DMA_BASE; ch = (rel / 12) % 4; sub = rel % 12;
        if (sub < 4) dsrc[ch][8*sub +: 8] = d;
        else if (sub < 8) dtgt[ch][8*(sub-4) +: 8] = d;
        else if (sub == 8) dlen[ch][7:0] = d;
        else if (sub == 9) dlen[ch][15:8] = d;
        else if (sub == 10) dctl[ch] = (dctl[ch] & 16'hFF0) | ((d >> 4) & 8'hE);
        else begin
          was = dctl[ch][11];
          if (ch != 3) d[3] = 1'b0;
          dctl[ch] = (dctl[ch] & 16'h00F) | ({8'h0, d} << 4);
          if (!was && d[7]) begin
            if (d[5:4] == 2'b00) dpend[ch] = 1;
            run_src[ch] = dsrc[ch]; run_tgt[ch] = dtgt[ch]; run_len[ch] = dlen[ch];
            o.dma_start[ch] = 1'b1;
          end else if (!d[7]) begin
            dpend[ch] = 0;
          end
        end
      end else if (a >= 12'h100 && a <= 12'h10F) begin
        t = a[3:2];
        if (a[1:0] == 0) treload[t][7:0] = d;
        else if (a[1:0] == 1) treload[t][15:8] = d;
        else if (a[1:0] == 2) begin
          was = tctl[t][4];
          tctl[t] = {d[7:6], d[2:0]};
          if (!was && d[7]) begin
            tpend[t] = 1;
            o.timer_start[t] = 1'b1;
          end
        end
      end else if (a >= 12'h120 && a <= 12'h127) begin
        if (a[0]) swords[a[2:1]][15:8] = d;
        else swords[a[2:1]][7:0] = d;
      end else if (a >= 12'h150 && a <= 12'h153) begin
        lrx[8*a[1:0] +: 8] = d;
      end else if (a >= 12'h154 && a <= 12'h157) begin
        ltx[8*a[1:0] +: 8] = d;
      end else begin
        case (a)
          12'h128: sctl = {sctl[6:5], d[7], d[3:0]};
          12'h129: sctl = {d[6], d[4], sctl[4:0]};
          12'h12A: sbyte = d;
          12'h132: kctl[7:0] = d;
          12'h133: kctl[11:8] = {d[7:6], d[1:0]};
          12'h134: lset[7:0] = d;
          12'h135: lset[10:8] = {d[7:6], d[0]};
          12'h140: lctl = {d[6], d[2:0]};
          12'h158: lstat = {d[5:4], d[3], d[1]};
          12'h200: ie[7:0] = d;
          12'h201: ie[15:8] = d;
          12'h202: iflag[7:0] = iflag[7:0] & ~d;
          12'h203: iflag[15:8] = iflag[15:8] & ~d;
          12'h204: waitc[7:0] = d;
          12'h205: waitc[14:8] = {d[7:6], 1'b0, d[3:0]};
          12'h208: ime = d[0];
          12'h300: if (d[0]) boot = 1'b1;
          12'h301: o.power_request = d[7] ? PWR_STOP : PWR_HALT;
          12'h800: memc[4:0] = {d[5], d[3:0]};
          12'h803: memc[12:5] = d;
          default: ;
        endcase
      end
    endfunction

    function void note_access(in_item_t it);
      out_item_t o;
      o = '0;
      if (it.cmd == CMD_WRITE) write_byte(it, o);
      else o.rdata = read_byte(it);
      iflag = iflag | it.irq_raise;
      if (o.dma_start != 0) dma_pulses++;
      if (o.timer_start != 0) timer_pulses++;
      if (o.power_request != PWR_NONE) power_hits++;
      pending_q.push_back(o);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: %h", got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (got.rdata !== want.rdata) begin
        $error("rdata exp %h got %h", want.rdata, got.rdata); errors++;
      end
      if (got.dma_start !== want.dma_start) begin
        $error("dma_start exp %h got %h", want.dma_start, got.dma_start); errors++;
      end
      if (got.timer_start !== want.timer_start) begin
        $error("timer_start exp %h got %h", want.timer_start, got.timer_start); errors++;
      end
      if (got.power_request !== want.power_request) begin
        $error("power_request exp %h got %h", want.power_request, got.power_request);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  bus_scoreboard sb;
  int            gap_max;

  handheld_io_register_file u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_item);
  end

  // Hold start through the accepting edge; drop it only while idling.
  task automatic send_beat(input in_item_t it);
    int gap;
    gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_access(it);
    @(negedge clk);
  endtask

  task automatic access(input logic c, input logic [11:0] a, input logic [7:0] d);
    in_item_t it;
    it.cmd = c;
    it.addr_offset = a;
    it.wdata = d;
    it.keys_pressed = $urandom_range(1023, 0);
    it.timer_count = $urandom_range(65535, 0);
    it.irq_raise = ($urandom_range(3, 0) == 0) ? $urandom_range(65535, 0) : 16'h0;
    send_beat(it);
  endtask

  function automatic logic [11:0] pick_addr();
    logic [11:0] mapped[] = '{12'h128, 12'h129, 12'h12A, 12'h130, 12'h131, 12'h132,
                              12'h133, 12'h134, 12'h135, 12'h140, 12'h158, 12'h200,
                              12'h201, 12'h202, 12'h203, 12'h204, 12'h205, 12'h208,
                              12'h300, 12'h301, 12'h800, 12'h803};
    int sel;
    sel = $urandom_range(9, 0);
    case (sel)
      0, 1, 2: return DMA_BASE + $urandom_range(47, 0);
      3:       return 12'h100 + $urandom_range(15, 0);
      4:       return 12'h120 + $urandom_range(7, 0);
      5:       return 12'h150 + $urandom_range(7, 0);
      6, 7:    return mapped[$urandom_range(mapped.size() - 1, 0)];
      default: return $urandom_range(4095, 0);
    endcase
  endfunction

  initial begin
    #1000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    in_item_t it;
    int        ch;
    sb = new();
    gap_max = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: keypad cancel and extremes, DMA window bounds, timers, power, boot, flags.
    it = '0; it.cmd = CMD_READ; it.addr_offset = 12'h130; it.keys_pressed = 10'h3FF;
    send_beat(it);
    it.keys_pressed = 10'h000; send_beat(it);
    it.addr_offset = 12'h131; it.keys_pressed = 10'h2AA; send_beat(it);
    it.addr_offset = 12'h100; it.timer_count = 16'hFFFF; send_beat(it);
    it.addr_offset = 12'h10D; send_beat(it);
    it.cmd = CMD_WRITE; it.addr_offset = 12'h200; it.wdata = 8'h00;
    it.irq_raise = 16'hFFFF; send_beat(it);
    access(CMD_READ, 12'h203, 0);
    access(CMD_WRITE, 12'h202, 8'hFF);
    access(CMD_READ, 12'h202, 0);
    access(CMD_WRITE, DMA_BASE + 0, 8'hFF);
    access(CMD_WRITE, DMA_BASE + 11, 8'hFF);
    access(CMD_READ, DMA_BASE + 11, 0);
    access(CMD_WRITE, DMA_BASE + 11, 8'hBF);
    access(CMD_WRITE, DMA_BASE + 11, 8'h00);
    access(CMD_WRITE, DMA_BASE + 47, 8'h8F);
    access(CMD_READ, DMA_BASE + 47, 0);
    access(CMD_WRITE, DMA_BASE + 46, 8'hFF);
    access(CMD_READ, DMA_BASE + 46, 0);
    access(CMD_WRITE, 12'h10A, 8'hC7);
    access(CMD_READ, 12'h10A, 0);
    access(CMD_WRITE, 12'h300, 8'h00);
    access(CMD_WRITE, 12'h300, 8'h01);
    access(CMD_WRITE, 12'h301, 8'h80);
    access(CMD_WRITE, 12'h301, 8'h00);
    access(CMD_READ, 12'hFFF, 0);

    // Wait out every outstanding result before the random phase.
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);

    for (int n = 0; n < 1250; n++) begin
      if (n % 200 == 0) gap_max = (n % 400 == 0) ? 0 : 12;
      if ($urandom_range(5, 0) == 0) begin
        // DMA control sequence: disable, then enable with random mode.
        ch = $urandom_range(3, 0);
        access(CMD_WRITE, DMA_BASE + 12 * ch + 11, $urandom_range(127, 0));
        access(CMD_WRITE, DMA_BASE + 12 * ch + 11, 8'h80 | $urandom_range(127, 0));
        n++;
      end else if ($urandom_range(7, 0) == 0) begin
        ch = $urandom_range(3, 0);
        access(CMD_WRITE, 12'h102 + 4 * ch, $urandom_range(255, 0));
      end else begin
        access($urandom_range(1, 0), pick_addr(), $urandom_range(255, 0));
      end
    end

    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    $display("Checked %0d bus results; %0d DMA starts, %0d timer starts, %0d power requests.",
             sb.checked, sb.dma_pulses, sb.timer_pulses, sb.power_hits);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
